// File: rtl/gss_pkg.sv
// ----------------------------------------------------------------------------
// Gear shift sequencer package
// Shared item codes, phase encodings, register indexes and reset values.
// ----------------------------------------------------------------------------
package gss_pkg;

    // Item kinds on the input channel.
    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_UP   = 2'd1,
        KIND_DOWN = 2'd2
    } kind_t;

    // Shift sequencer state, one-hot.
    typedef enum logic [5:0] {
        PH_MANUAL     = 6'b000001,
        PH_IGN_CUT    = 6'b000010,
        PH_CLUTCH_IN  = 6'b000100,
        PH_SOL_ON     = 6'b001000,
        PH_SOL_OFF    = 6'b010000,
        PH_CLUTCH_OUT = 6'b100000
    } phase_t;

    // Phase codes as reported on the result channel.
    localparam logic [2:0] PHASE_CODE_MANUAL     = 3'd0;
    localparam logic [2:0] PHASE_CODE_IGN_CUT    = 3'd1;
    localparam logic [2:0] PHASE_CODE_CLUTCH_IN  = 3'd2;
    localparam logic [2:0] PHASE_CODE_SOL_ON     = 3'd3;
    localparam logic [2:0] PHASE_CODE_SOL_OFF    = 3'd4;
    localparam logic [2:0] PHASE_CODE_CLUTCH_OUT = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] REG_SERVO_START   = 3'd0;
    localparam logic [2:0] REG_SERVO_END     = 3'd1;
    localparam logic [2:0] REG_UP_DELAY      = 3'd2;
    localparam logic [2:0] REG_DOWN_DELAY    = 3'd3;
    localparam logic [2:0] REG_SOLENOID      = 3'd4;
    localparam logic [2:0] REG_CLUTCH_TMO    = 3'd5;
    localparam logic [2:0] REG_RPM_THRESHOLD = 3'd6;

    // Register reset values.
    localparam logic [11:0] RST_SERVO_START   = 12'd2000;
    localparam logic [11:0] RST_SERVO_END     = 12'd1000;
    localparam logic [15:0] RST_UP_DELAY      = 16'd50;
    localparam logic [15:0] RST_DOWN_DELAY    = 16'd100;
    localparam logic [15:0] RST_SOLENOID      = 16'd80;
    localparam logic [15:0] RST_CLUTCH_TMO    = 16'd200;
    localparam logic [13:0] RST_RPM_THRESHOLD = 14'd4000;

    localparam logic [6:0]  LEVER_FULL = 7'd100;

    // floor(x / 100) == (x * DIV100_MULT) >> DIV100_SHIFT for every x < 2**19.
    localparam int          DIV100_SHIFT = 26;
    localparam logic [19:0] DIV100_MULT  = 20'd671089;

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        case (ph)
            PH_MANUAL:     code = PHASE_CODE_MANUAL;
            PH_IGN_CUT:    code = PHASE_CODE_IGN_CUT;
            PH_CLUTCH_IN:  code = PHASE_CODE_CLUTCH_IN;
            PH_SOL_ON:     code = PHASE_CODE_SOL_ON;
            PH_SOL_OFF:    code = PHASE_CODE_SOL_OFF;
            PH_CLUTCH_OUT: code = PHASE_CODE_CLUTCH_OUT;
            default:       code = PHASE_CODE_MANUAL;
        endcase
        return code;
    endfunction

endpackage

// File: rtl/gear_shift_sequencer_core.sv
// ----------------------------------------------------------------------------
// Gear shift sequencer core
// Paddle shift sequencing with spark cut, clutch servo and shift solenoids.
// ----------------------------------------------------------------------------
// Each input beat is a 1 ms tick, a shift up/down request or the spare kind,
// which changes nothing; each carries the clutch lever percent and the engine
// rpm. Every input beat yields exactly one result beat showing the servo pulse,
// the three output lines and the phase after that item, plus a flag for a
// refused shift request. The input stage registers the item together with the
// lever-times-span product; when that stage advances, the product is divided
// by 100 and clamped and the sequencer is updated, and its state registers
// drive the result fields directly. A new beat is taken every cycle while
// results are drained. When the receiver stalls, the result holds and the
// input stage fills, after which in_ready drops until out_ready returns.
// Reset clears both stages, puts the sequencer in the manual phase with all
// lines off and the servo at its reset start value, and loads the register
// reset values. Configuration writes take effect on the next edge. The user
// must make them only while no beat is in flight; the block itself does not
// enforce this.
// ----------------------------------------------------------------------------
module gear_shift_sequencer_core
    import gss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [6:0]  clutch_lever,
    input  logic [13:0] engine_rpm,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] servo_pulse,
    output logic        ignition_cut,
    output logic        up_solenoid,
    output logic        down_solenoid,
    output logic [2:0]  phase,
    output logic        shift_rejected
);

    // Configuration registers
    logic [11:0] servo_start_reg;
    logic [11:0] servo_end_reg;
    logic [15:0] up_delay_reg;
    logic [15:0] down_delay_reg;
    logic [15:0] solenoid_reg;
    logic [15:0] clutch_tmo_reg;
    logic [13:0] rpm_threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servo_start_reg   <= RST_SERVO_START;
            servo_end_reg     <= RST_SERVO_END;
            up_delay_reg      <= RST_UP_DELAY;
            down_delay_reg    <= RST_DOWN_DELAY;
            solenoid_reg      <= RST_SOLENOID;
            clutch_tmo_reg    <= RST_CLUTCH_TMO;
            rpm_threshold_reg <= RST_RPM_THRESHOLD;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SERVO_START:   servo_start_reg   <= cfg_data[11:0];
                REG_SERVO_END:     servo_end_reg     <= cfg_data[11:0];
                REG_UP_DELAY:      up_delay_reg      <= cfg_data;
                REG_DOWN_DELAY:    down_delay_reg    <= cfg_data;
                REG_SOLENOID:      solenoid_reg      <= cfg_data;
                REG_CLUTCH_TMO:    clutch_tmo_reg    <= cfg_data;
                REG_RPM_THRESHOLD: rpm_threshold_reg <= cfg_data[13:0];
                default:           ;
            endcase
        end
    end

    // Input stage: lever clamp and lever * (end - start) product.
    logic               s1_valid_reg;
    logic [1:0]         s1_kind_reg;
    logic [13:0]        s1_rpm_reg;
    logic signed [19:0] s1_prod_reg;
    logic               s1_advance;
    logic               in_accept;

    logic [6:0]         lever_clamped;
    logic signed [12:0] servo_span;
    logic signed [20:0] prod_full;

    assign lever_clamped = (clutch_lever > LEVER_FULL) ? LEVER_FULL : clutch_lever;
    assign servo_span    = $signed({1'b0, servo_end_reg}) - $signed({1'b0, servo_start_reg});
    assign prod_full     = $signed({1'b0, lever_clamped}) * servo_span;

    logic out_valid_reg;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_kind_reg <= kind;
            s1_rpm_reg  <= engine_rpm;
            s1_prod_reg <= prod_full[19:0];
        end
    end

    // Manual map: start + trunc(product / 100), then the end/start clamp.
    logic               prod_neg;
    logic [18:0]        prod_mag;
    logic [38:0]        quot_full;
    logic [11:0]        quot;
    logic signed [13:0] quot_signed;
    logic signed [13:0] map_value;
    logic [11:0]        map_clamped;
    logic [11:0]        end_clamped;
    logic [11:0]        start_clamped;

    assign prod_neg    = s1_prod_reg[19];
    assign prod_mag    = prod_neg ? 19'(-s1_prod_reg) : s1_prod_reg[18:0];
    assign quot_full   = prod_mag * DIV100_MULT;
    assign quot        = quot_full[DIV100_SHIFT +: 12];
    assign quot_signed = prod_neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
    assign map_value   = $signed({2'b00, servo_start_reg}) + quot_signed;

    always_comb
    begin
        if (map_value < $signed({2'b00, servo_end_reg}))
        begin
            map_clamped = servo_end_reg;
        end
        else if (map_value > $signed({2'b00, servo_start_reg}))
        begin
            map_clamped = servo_start_reg;
        end
        else
        begin
            map_clamped = map_value[11:0];
        end
    end

    assign end_clamped   = (servo_end_reg > servo_start_reg) ? servo_start_reg : servo_end_reg;
    assign start_clamped = (servo_start_reg < servo_end_reg) ? servo_end_reg : servo_start_reg;

    // Sequencer state; these registers also form the result beat.
    phase_t      phase_reg,      phase_next;
    logic [15:0] elapsed_reg,    elapsed_next;
    logic        entry_done_reg, entry_done_next;
    logic        shift_down_reg, shift_down_next;
    logic        uses_clutch_reg, uses_clutch_next;
    logic [11:0] servo_reg,      servo_next;
    logic        spark_reg,      spark_next;
    logic        up_sol_reg,     up_sol_next;
    logic        down_sol_reg,   down_sol_next;
    logic        rejected_reg,   rejected_next;

    logic        first_tick;
    logic [15:0] wait_delay;
    phase_t      wait_target;
    logic        wait_done;

    assign first_tick = !entry_done_reg;
    assign wait_done  = (elapsed_reg >= wait_delay);

    always_comb
    begin
        case (phase_reg)
            PH_IGN_CUT:
            begin
                wait_delay  = up_delay_reg;
                wait_target = PH_SOL_ON;
            end
            PH_CLUTCH_IN:
            begin
                wait_delay  = down_delay_reg;
                wait_target = PH_SOL_ON;
            end
            PH_SOL_ON:
            begin
                wait_delay  = solenoid_reg;
                wait_target = PH_SOL_OFF;
            end
            PH_SOL_OFF:
            begin
                wait_delay  = clutch_tmo_reg;
                wait_target = PH_CLUTCH_OUT;
            end
            default:
            begin
                wait_delay  = 16'd0;
                wait_target = PH_MANUAL;
            end
        endcase
    end

    always_comb
    begin
        phase_next       = phase_reg;
        elapsed_next     = elapsed_reg;
        entry_done_next  = entry_done_reg;
        shift_down_next  = shift_down_reg;
        uses_clutch_next = uses_clutch_reg;
        servo_next       = servo_reg;
        spark_next       = spark_reg;
        up_sol_next      = up_sol_reg;
        down_sol_next    = down_sol_reg;
        rejected_next    = 1'b0;

        case (s1_kind_reg)
            KIND_TICK:
            begin
                entry_done_next = 1'b1;
                case (phase_reg)
                    PH_MANUAL:
                    begin
                        servo_next      = map_clamped;
                        entry_done_next = 1'b0;
                    end
                    PH_IGN_CUT, PH_CLUTCH_IN, PH_SOL_ON:
                    begin
                        if (first_tick && phase_reg == PH_IGN_CUT)
                        begin
                            spark_next = 1'b1;
                        end
                        if (first_tick && phase_reg == PH_CLUTCH_IN)
                        begin
                            servo_next = end_clamped;
                        end
                        if (first_tick && phase_reg == PH_SOL_ON)
                        begin
                            if (shift_down_reg)
                            begin
                                down_sol_next = 1'b1;
                            end
                            else
                            begin
                                up_sol_next = 1'b1;
                            end
                        end
                        if (wait_done)
                        begin
                            phase_next      = wait_target;
                            elapsed_next    = 16'd0;
                            entry_done_next = 1'b0;
                        end
                        else if (elapsed_reg != 16'hFFFF)
                        begin
                            elapsed_next = elapsed_reg + 16'd1;
                        end
                    end
                    PH_SOL_OFF:
                    begin
                        if (first_tick)
                        begin
                            spark_next = 1'b0;
                            if (shift_down_reg)
                            begin
                                down_sol_next = 1'b0;
                            end
                            else
                            begin
                                up_sol_next = 1'b0;
                            end
                        end
                        if (!uses_clutch_reg || wait_done)
                        begin
                            phase_next      = uses_clutch_reg ? PH_CLUTCH_OUT : PH_MANUAL;
                            elapsed_next    = 16'd0;
                            entry_done_next = 1'b0;
                        end
                        else if (elapsed_reg != 16'hFFFF)
                        begin
                            elapsed_next = elapsed_reg + 16'd1;
                        end
                    end
                    PH_CLUTCH_OUT:
                    begin
                        servo_next      = start_clamped;
                        phase_next      = PH_MANUAL;
                        elapsed_next    = 16'd0;
                        entry_done_next = 1'b0;
                    end
                    default:
                    begin
                        phase_next      = PH_MANUAL;
                        elapsed_next    = 16'd0;
                        entry_done_next = 1'b0;
                    end
                endcase
            end
            KIND_UP, KIND_DOWN:
            begin
                // A new shift may start only from manual or clutch out.
                if (phase_reg != PH_MANUAL && phase_reg != PH_CLUTCH_OUT)
                begin
                    rejected_next = 1'b1;
                end
                else
                begin
                    elapsed_next    = 16'd0;
                    entry_done_next = 1'b0;
                    if (s1_kind_reg == KIND_UP && s1_rpm_reg >= rpm_threshold_reg)
                    begin
                        shift_down_next  = 1'b0;
                        uses_clutch_next = 1'b0;
                        phase_next       = PH_IGN_CUT;
                    end
                    else
                    begin
                        shift_down_next  = (s1_kind_reg == KIND_DOWN);
                        uses_clutch_next = 1'b1;
                        phase_next       = PH_CLUTCH_IN;
                    end
                end
            end
            default:
            begin
                rejected_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_MANUAL;
            elapsed_reg     <= 16'd0;
            entry_done_reg  <= 1'b0;
            shift_down_reg  <= 1'b0;
            uses_clutch_reg <= 1'b0;
            servo_reg       <= RST_SERVO_START;
            spark_reg       <= 1'b0;
            up_sol_reg      <= 1'b0;
            down_sol_reg    <= 1'b0;
            rejected_reg    <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                out_valid_reg   <= 1'b1;
                phase_reg       <= phase_next;
                elapsed_reg     <= elapsed_next;
                entry_done_reg  <= entry_done_next;
                shift_down_reg  <= shift_down_next;
                uses_clutch_reg <= uses_clutch_next;
                servo_reg       <= servo_next;
                spark_reg       <= spark_next;
                up_sol_reg      <= up_sol_next;
                down_sol_reg    <= down_sol_next;
                rejected_reg    <= rejected_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign servo_pulse    = servo_reg;
    assign ignition_cut   = spark_reg;
    assign up_solenoid    = up_sol_reg;
    assign down_solenoid  = down_sol_reg;
    assign phase          = phase_code(phase_reg);
    assign shift_rejected = rejected_reg;

endmodule

// File: rtl/gss_checker.sv
// ----------------------------------------------------------------------------
// Gear shift sequencer port checker
// Checks sequencing rules visible on the ports of the core.
// ----------------------------------------------------------------------------
module gss_checker
    import gss_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [11:0] servo_pulse,
    input logic        ignition_cut,
    input logic        up_solenoid,
    input logic        down_solenoid,
    input logic [2:0]  phase,
    input logic        shift_rejected
);

    // Only one shift solenoid is ever powered.
    a_one_solenoid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(up_solenoid && down_solenoid))
        else $error("both shift solenoids powered");

    // A refused request leaves the sequencer in a phase that refuses shifts.
    a_reject_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && shift_rejected) |->
            (phase != PHASE_CODE_MANUAL && phase != PHASE_CODE_CLUTCH_OUT))
        else $error("shift refused outside a running shift");

    // Spark is cut only during spark cut, solenoid on or the step into solenoid off.
    a_spark_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ignition_cut) |->
            (phase == PHASE_CODE_IGN_CUT || phase == PHASE_CODE_SOL_ON ||
             phase == PHASE_CODE_SOL_OFF))
        else $error("spark cut outside an up shift");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(servo_pulse) && $stable(phase) &&
             $stable(shift_rejected)))
        else $error("result beat changed while stalled");

endmodule

bind gear_shift_sequencer_core gss_checker u_gss_checker (.*);

// File: bench/gear_shift_sequencer_core_tb.sv
// ----------------------------------------------------------------------------
// Gear shift sequencer core testbench
// Drives ticks and shift requests under random input gaps and output stalls.
// A scoreboard tracks its own copy of the shift sequencer and compares every
// result beat with the outputs it predicts. Several register settings are
// visited, including zero and maximum delays and a servo start below the end.
// ----------------------------------------------------------------------------
module gear_shift_sequencer_core_tb;
    import gss_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam logic [2:0] LINE_SPARK = 3'b001;
    localparam logic [2:0] LINE_UP    = 3'b010;
    localparam logic [2:0] LINE_DOWN  = 3'b100;
    localparam int LONG_STALL  = 60;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [11:0] servo_pulse;
        logic        ignition_cut;
        logic        up_solenoid;
        logic        down_solenoid;
        logic [2:0]  phase;
        logic        shift_rejected;
    } shift_outputs_t;

    class shift_scoreboard;
        logic [11:0] start_us;
        logic [11:0] end_us;
        logic [15:0] up_wait;
        logic [15:0] down_wait;
        logic [15:0] sol_time;
        logic [15:0] release_wait;
        logic [13:0] spark_rpm;

        logic [2:0]  seq_phase;
        logic [15:0] elapsed;
        bit          entered;
        bit          down_shift;
        bit          clutch_shift;
        logic [11:0] servo;
        logic [2:0]  lines;

        shift_outputs_t pending_outputs[$];
        int errors;

        function new();
            start_us = RST_SERVO_START;
            end_us = RST_SERVO_END;
            up_wait = RST_UP_DELAY;
            down_wait = RST_DOWN_DELAY;
            sol_time = RST_SOLENOID;
            release_wait = RST_CLUTCH_TMO;
            spark_rpm = RST_RPM_THRESHOLD;
            seq_phase = PHASE_CODE_MANUAL;
            elapsed = '0;
            entered = 0;
            down_shift = 0;
            clutch_shift = 0;
            servo = RST_SERVO_START;
            lines = '0;
            errors = 0;
        endfunction

        function void set_register(input logic [2:0] idx, input logic [15:0] val);
            case (idx)
                REG_SERVO_START:   start_us = val[11:0];
                REG_SERVO_END:     end_us = val[11:0];
                REG_UP_DELAY:      up_wait = val;
                REG_DOWN_DELAY:    down_wait = val;
                REG_SOLENOID:      sol_time = val;
                REG_CLUTCH_TMO:    release_wait = val;
                REG_RPM_THRESHOLD: spark_rpm = val[13:0];
                default:           ;
            endcase
        endfunction

        // When start lies below end, values below end give end and all others give start.
        function logic [11:0] fit_servo(input int v);
            if (v < int'(end_us))
                v = int'(end_us);
            else if (v > int'(start_us))
                v = int'(start_us);
            return v[11:0];
        endfunction

        function void enter(input logic [2:0] next);
            seq_phase = next;
            elapsed = '0;
            entered = 0;
        endfunction

        function void hold_or_move(input logic [15:0] delay, input logic [2:0] next);
            if (elapsed >= delay)
                enter(next);
            else if (elapsed != 16'hFFFF)
                elapsed = elapsed + 16'd1;
        endfunction

        function logic [2:0] solenoid_line();
            return down_shift ? LINE_DOWN : LINE_UP;
        endfunction

        function void advance_one_ms(input int lever);
            bit first;
            int span;
            first = !entered;
            entered = 1;
            case (seq_phase)
                PHASE_CODE_MANUAL:
                begin
                    span = int'(end_us) - int'(start_us);
                    servo = fit_servo(int'(start_us) + (lever * span) / int'(LEVER_FULL));
                    entered = 0;
                end
                PHASE_CODE_IGN_CUT:
                begin
                    if (first)
                        lines = lines | LINE_SPARK;
                    hold_or_move(up_wait, PHASE_CODE_SOL_ON);
                end
                PHASE_CODE_CLUTCH_IN:
                begin
                    if (first)
                        servo = fit_servo(int'(end_us));
                    hold_or_move(down_wait, PHASE_CODE_SOL_ON);
                end
                PHASE_CODE_SOL_ON:
                begin
                    if (first)
                        lines = lines | solenoid_line();
                    hold_or_move(sol_time, PHASE_CODE_SOL_OFF);
                end
                PHASE_CODE_SOL_OFF:
                begin
                    if (first)
                        lines = lines & ~(solenoid_line() | LINE_SPARK);
                    if (clutch_shift)
                        hold_or_move(release_wait, PHASE_CODE_CLUTCH_OUT);
                    else
                        enter(PHASE_CODE_MANUAL);
                end
                PHASE_CODE_CLUTCH_OUT:
                begin
                    servo = fit_servo(int'(start_us));
                    enter(PHASE_CODE_MANUAL);
                end
                default:
                    enter(PHASE_CODE_MANUAL);
            endcase
        endfunction

        function void note_input(input logic [1:0] k, input logic [6:0] lever,
                                 input logic [13:0] rpm);
            shift_outputs_t want;
            int lv;
            bit refused;
            lv = (lever > LEVER_FULL) ? int'(LEVER_FULL) : int'(lever);
            refused = 0;
            if (k == KIND_TICK)
                advance_one_ms(lv);
            else if (k == KIND_UP || k == KIND_DOWN)
            begin
                if (seq_phase != PHASE_CODE_MANUAL && seq_phase != PHASE_CODE_CLUTCH_OUT)
                    refused = 1;
                else if (k == KIND_UP && rpm >= spark_rpm)
                begin
                    down_shift = 0;
                    clutch_shift = 0;
                    enter(PHASE_CODE_IGN_CUT);
                end
                else
                begin
                    down_shift = (k == KIND_DOWN);
                    clutch_shift = 1;
                    enter(PHASE_CODE_CLUTCH_IN);
                end
            end
            want.servo_pulse = servo;
            want.ignition_cut = lines[0];
            want.up_solenoid = lines[1];
            want.down_solenoid = lines[2];
            want.phase = seq_phase;
            want.shift_rejected = refused;
            pending_outputs.push_back(want);
        endfunction

        task report(input string msg);
            $display("tb mismatch: %s", msg);
            errors++;
        endtask

        task check_result(input shift_outputs_t got);
            shift_outputs_t want;
            if (pending_outputs.size() == 0)
            begin
                report("result beat with no item outstanding");
                return;
            end
            want = pending_outputs.pop_front();
            if (got.servo_pulse !== want.servo_pulse)
                report($sformatf("servo_pulse %0d, expected %0d",
                                 got.servo_pulse, want.servo_pulse));
            if (got.ignition_cut !== want.ignition_cut)
                report($sformatf("ignition_cut %b, expected %b",
                                 got.ignition_cut, want.ignition_cut));
            if (got.up_solenoid !== want.up_solenoid)
                report($sformatf("up_solenoid %b, expected %b",
                                 got.up_solenoid, want.up_solenoid));
            if (got.down_solenoid !== want.down_solenoid)
                report($sformatf("down_solenoid %b, expected %b",
                                 got.down_solenoid, want.down_solenoid));
            if (got.phase !== want.phase)
                report($sformatf("phase %0d, expected %0d", got.phase, want.phase));
            if (got.shift_rejected !== want.shift_rejected)
                report($sformatf("shift_rejected %b, expected %b",
                                 got.shift_rejected, want.shift_rejected));
        endtask

        function int outstanding();
            return pending_outputs.size();
        endfunction

        function logic [2:0] phase_now();
            return seq_phase;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  kind;
    logic [6:0]  clutch_lever;
    logic [13:0] engine_rpm;
    logic        out_valid;
    logic        out_ready;
    logic [11:0] servo_pulse;
    logic        ignition_cut;
    logic        up_solenoid;
    logic        down_solenoid;
    logic [2:0]  phase;
    logic        shift_rejected;

    shift_scoreboard sb;
    bit source_steady = 0;
    bit sink_steady = 0;
    bit sink_hold = 0;
    int quiet_cycles = 0;

    gear_shift_sequencer_core DUT (.*);

    always #2 clk = ~clk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        else if (roll < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [6:0] pick_lever();
        if ($urandom_range(0, 9) == 0)
            return 7'($urandom_range(101, 127));
        return 7'($urandom_range(0, 100));
    endfunction

    // Half of the rpm values sit right around the spark cut threshold.
    function automatic logic [13:0] pick_rpm();
        int r;
        if ($urandom_range(0, 1) == 0)
            return 14'($urandom_range(0, 16383));
        r = int'(sb.spark_rpm) + $urandom_range(0, 4) - 2;
        if (r < 0)
            r = 0;
        if (r > 16383)
            r = 16383;
        return r[13:0];
    endfunction

    function automatic logic [1:0] pick_shift();
        return ($urandom_range(0, 1) == 0) ? KIND_UP : KIND_DOWN;
    endfunction

    task automatic offer(input logic [1:0] k, input logic [6:0] lever, input logic [13:0] rpm);
        int gap;
        in_valid <= 1'b1;
        kind <= k;
        clutch_lever <= lever;
        engine_rpm <= rpm;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(k, lever, rpm);
        gap = source_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic ticks(input int count, input logic [6:0] lever);
        repeat (count) offer(KIND_TICK, lever, 14'($urandom_range(0, 16383)));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_register(idx, val);
        @(posedge clk);
    endtask

    task automatic configure(input logic [11:0] start_us, input logic [11:0] end_us,
                             input logic [15:0] up_ms, input logic [15:0] down_ms,
                             input logic [15:0] sol_ms, input logic [15:0] release_ms,
                             input logic [13:0] threshold);
        wait_for_results();
        write_reg(REG_SERVO_START, {4'b0000, start_us});
        write_reg(REG_SERVO_END, {4'b0000, end_us});
        write_reg(REG_UP_DELAY, up_ms);
        write_reg(REG_DOWN_DELAY, down_ms);
        write_reg(REG_SOLENOID, sol_ms);
        write_reg(REG_CLUTCH_TMO, release_ms);
        write_reg(REG_RPM_THRESHOLD, {2'b00, threshold});
    endtask

    // Mostly whole shifts: a request, then up to forty ticks until back in manual,
    // with shifts thrown in during the shift and at clutch out.
    task automatic shift_traffic(input int count);
        int sent;
        int steps;
        logic [1:0] k;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                offer(pick_shift(), pick_lever(), pick_rpm());
                sent++;
                steps = 0;
                while (sb.phase_now() != PHASE_CODE_MANUAL && steps < 40)
                begin
                    if (sb.phase_now() == PHASE_CODE_CLUTCH_OUT && $urandom_range(0, 3) == 0)
                        k = pick_shift();
                    else if ($urandom_range(0, 19) == 0)
                        k = pick_shift();
                    else
                        k = KIND_TICK;
                    offer(k, pick_lever(), pick_rpm());
                    sent++;
                    steps++;
                end
                repeat ($urandom_range(0, 3))
                begin
                    offer(KIND_TICK, pick_lever(), pick_rpm());
                    sent++;
                end
            end
            else
            begin
                k = 2'($urandom_range(0, 3));
                offer(k, 7'($urandom_range(0, 127)), 14'($urandom_range(0, 16383)));
                if (k != KIND_SPARE)
                    sent++;
            end
        end
    endtask

    // Result side: random ready runs, a steady mode and one long hold-off.
    initial
    begin : sink
        int run;
        out_ready = 1'b0;
        forever
        begin
            if (sink_hold)
            begin
                sink_hold = 0;
                out_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
            end
            else if (sink_steady)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 99) < 65)
            begin
                out_ready <= 1'b1;
                run = $urandom_range(1, 8);
                repeat (run) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                run = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                   : $urandom_range(10, 30);
                repeat (run) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        shift_outputs_t seen;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen = '{servo_pulse, ignition_cut, up_solenoid, down_solenoid,
                         phase, shift_rejected};
                sb.check_result(seen);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_SERVO_START;
        cfg_data = '0;
        in_valid = 1'b0;
        kind = KIND_TICK;
        clutch_lever = '0;
        engine_rpm = '0;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Manual map at the lever extremes, a lever above full, and the spare kind.
        offer(KIND_TICK, 7'd0, 14'd0);
        offer(KIND_TICK, LEVER_FULL, 14'd16383);
        offer(KIND_TICK, 7'd127, 14'd0);
        offer(KIND_TICK, 7'd50, 14'd16383);
        offer(KIND_SPARE, 7'd127, 14'd16383);

        // Short delays so that whole shifts fit in a few beats.
        configure(12'd2000, 12'd1000, 16'd1, 16'd0, 16'd0, 16'd1, 14'd4000);
        offer(KIND_UP, 7'd10, 14'd4000);
        offer(KIND_DOWN, 7'd10, 14'd4000);
        ticks(4, 7'd30);
        offer(KIND_UP, 7'd80, 14'd3999);
        ticks(4, 7'd80);
        offer(KIND_DOWN, 7'd0, 14'd0);
        ticks(5, 7'd127);
        offer(KIND_UP, 7'd0, 14'd16383);

        configure(12'd2000, 12'd1000, 16'd3, 16'd2, 16'd1, 16'd2, 14'd4000);
        shift_traffic(100);
        wait_for_results();
        shift_traffic(100);

        // Start below end, zero delays, and every up shift through spark cut.
        configure(12'd0, 12'd4095, 16'd0, 16'd0, 16'd0, 16'd0, 14'd0);
        sink_hold = 1;
        while (sink_hold)
            @(posedge clk);
        source_steady = 1;
        shift_traffic(30);
        source_steady = 0;
        shift_traffic(170);

        configure(12'd4095, 12'd0, 16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                  16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)), 14'd16383);
        source_steady = 1;
        sink_steady = 1;
        shift_traffic(100);
        source_steady = 0;
        sink_steady = 0;
        shift_traffic(100);

        configure(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                  16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)),
                  16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)),
                  14'($urandom_range(0, 16383)));
        shift_traffic(150);

        // Longest delays: shifts stall in their first phase and later ones are refused.
        configure(12'd1500, 12'd1500, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 14'd8000);
        shift_traffic(60);

        wait_for_results();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
rtl/gss_pkg.sv
rtl/gear_shift_sequencer_core.sv
rtl/gss_checker.sv
bench/gear_shift_sequencer_core_tb.sv
